FILE: rtl/core/ntmb_pkg.sv
// Shared types and constants for the tanh backpropagation neuron.
// Holds request and result structs, mode/kind/register codes, step codes and saturation.
// No dependencies.
package ntmb_pkg;

  localparam int DATA_W  = 16;
  localparam int ACC_W   = 40;
  localparam int MODE_W  = 2;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int OP_W    = 5;

  localparam logic [MODE_W-1:0] MODE_FORWARD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OUT_GRAD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HIDDEN   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UPDATE   = 2'd3;

  localparam logic [KIND_W-1:0] KIND_ACTIVATION = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GRADIENT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UPDATE     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM   = 2'd1;

  localparam logic [DATA_W-1:0] LEARN_RATE_RESET = 16'd9830;
  localparam logic [DATA_W-1:0] MOMENTUM_RESET   = 16'd32768;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // datapath step codes
  localparam logic [OP_W-1:0] OP_NONE   = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 5'd1;
  localparam logic [OP_W-1:0] OP_MUL_VW = 5'd2;
  localparam logic [OP_W-1:0] OP_ACC    = 5'd3;
  localparam logic [OP_W-1:0] OP_IDX    = 5'd4;
  localparam logic [OP_W-1:0] OP_ROM    = 5'd5;
  localparam logic [OP_W-1:0] OP_ACT    = 5'd6;
  localparam logic [OP_W-1:0] OP_MUL_AA = 5'd7;
  localparam logic [OP_W-1:0] OP_DERIV  = 5'd8;
  localparam logic [OP_W-1:0] OP_MUL_XD = 5'd9;
  localparam logic [OP_W-1:0] OP_GRAD_H = 5'd10;
  localparam logic [OP_W-1:0] OP_MUL_TD = 5'd11;
  localparam logic [OP_W-1:0] OP_GRAD_O = 5'd12;
  localparam logic [OP_W-1:0] OP_MUL_VG = 5'd13;
  localparam logic [OP_W-1:0] OP_MUL_LR = 5'd14;
  localparam logic [OP_W-1:0] OP_MUL_MO = 5'd15;
  localparam logic [OP_W-1:0] OP_UPD    = 5'd16;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] weight;
    logic signed [DATA_W-1:0] old_delta;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] result;
    logic signed [DATA_W-1:0] new_weight;
  } out_item_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } ntmb_cmd_t;

  typedef struct packed {
    logic out_free;
  } ntmb_status_t;

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) begin
      return 16'sh7fff;
    end else if (v < -64'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/core/neuron_tanh_mac_backprop_unit.sv
// Top level of the tanh backpropagation neuron (Q4.12 by default).
// Joins the step sequencer ntmb_ctrl and the datapath ntmb_datapath; uses ntmb_pkg.
//
// Usage:
//   Requests enter on in_valid/in_stall/in_item and are taken at an edge with in_valid
//   high and in_stall low. Results leave on out_valid/out_stall/out_item and are taken
//   at an edge with out_valid high and out_stall low. learn_rate (index 0) and momentum
//   (index 1) are written on cfg_valid/cfg_ready/cfg_index/cfg_data; the user must write
//   them only while idle, as the block does not enforce it. One request is processed at a
//   time; a single shared multiplier yields one product per cycle, and that product chain
//   sets the occupancy from acceptance to the next acceptance, for a sum term without last,
//   a forward sum's last term (accumulate, table index, registered ROM read), a hidden
//   sum's last term, an output gradient and a weight update. A result is valid in the
//   cycle after its final step. The output register holds one result; while it is held by
//   out_stall a new request may be taken, and its own result step waits until the
//   register frees. rst (synchronous) restores the register defaults, clears the
//   accumulator, activation and gradient, and drops any pending result; in_stall and
//   cfg_ready keep requests out while rst is high.
module neuron_tanh_mac_backprop_unit
  import ntmb_pkg::*;
#(
  parameter int FRAC_BITS        = 12,
  parameter int TANH_TABLE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  ntmb_cmd_t    cmd;
  ntmb_status_t status;

  assign cfg_ready = !rst;

  ntmb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_mode  (in_item.mode),
    .in_last  (in_item.last),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ntmb_datapath #(
    .FRAC_BITS        (FRAC_BITS),
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

FILE: rtl/core/ntmb_ctrl.sv
// Step sequencer for the tanh backpropagation neuron.
// Walks each request through the shared multiplier steps; uses ntmb_pkg.
module ntmb_ctrl
  import ntmb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [MODE_W-1:0] in_mode,
  input  logic              in_last,
  output logic              in_stall,
  input  ntmb_status_t      status,
  output ntmb_cmd_t         cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL_VW = 4'd1;
  localparam logic [3:0] S_ACC    = 4'd2;
  localparam logic [3:0] S_IDX    = 4'd3;
  localparam logic [3:0] S_ROM    = 4'd4;
  localparam logic [3:0] S_ACT    = 4'd5;
  localparam logic [3:0] S_MUL_AA = 4'd6;
  localparam logic [3:0] S_DERIV  = 4'd7;
  localparam logic [3:0] S_MUL_XD = 4'd8;
  localparam logic [3:0] S_GRAD_H = 4'd9;
  localparam logic [3:0] S_MUL_TD = 4'd10;
  localparam logic [3:0] S_GRAD_O = 4'd11;
  localparam logic [3:0] S_MUL_VG = 4'd12;
  localparam logic [3:0] S_MUL_LR = 4'd13;
  localparam logic [3:0] S_MUL_MO = 4'd14;
  localparam logic [3:0] S_UPD    = 4'd15;

  logic [3:0]        state;
  logic [3:0]        state_next;
  logic [MODE_W-1:0] mode_q;
  logic              last_q;

  assign in_stall = rst || (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          unique case (in_mode)
            MODE_FORWARD:  state_next = S_MUL_VW;
            MODE_HIDDEN:   state_next = S_MUL_VW;
            MODE_OUT_GRAD: state_next = S_MUL_AA;
            MODE_UPDATE:   state_next = S_MUL_VG;
            default:       state_next = S_IDLE;
          endcase
        end
      end
      S_MUL_VW: begin
        cmd.op     = OP_MUL_VW;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        priority if (!last_q) begin
          state_next = S_IDLE;
        end else if (mode_q == MODE_FORWARD) begin
          state_next = S_IDX;
        end else begin
          state_next = S_MUL_AA;
        end
      end
      S_IDX: begin
        cmd.op     = OP_IDX;
        state_next = S_ROM;
      end
      S_ROM: begin
        cmd.op     = OP_ROM;
        state_next = S_ACT;
      end
      S_ACT: begin
        // hold until the output register can take the result
        if (status.out_free) begin
          cmd.op     = OP_ACT;
          state_next = S_IDLE;
        end
      end
      S_MUL_AA: begin
        cmd.op     = OP_MUL_AA;
        state_next = S_DERIV;
      end
      S_DERIV: begin
        cmd.op     = OP_DERIV;
        state_next = (mode_q == MODE_OUT_GRAD) ? S_MUL_TD : S_MUL_XD;
      end
      S_MUL_XD: begin
        cmd.op     = OP_MUL_XD;
        state_next = S_GRAD_H;
      end
      S_GRAD_H: begin
        if (status.out_free) begin
          cmd.op     = OP_GRAD_H;
          state_next = S_IDLE;
        end
      end
      S_MUL_TD: begin
        cmd.op     = OP_MUL_TD;
        state_next = S_GRAD_O;
      end
      S_GRAD_O: begin
        if (status.out_free) begin
          cmd.op     = OP_GRAD_O;
          state_next = S_IDLE;
        end
      end
      S_MUL_VG: begin
        cmd.op     = OP_MUL_VG;
        state_next = S_MUL_LR;
      end
      S_MUL_LR: begin
        cmd.op     = OP_MUL_LR;
        state_next = S_MUL_MO;
      end
      S_MUL_MO: begin
        cmd.op     = OP_MUL_MO;
        state_next = S_UPD;
      end
      S_UPD: begin
        if (status.out_free) begin
          cmd.op     = OP_UPD;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      mode_q <= MODE_FORWARD;
      last_q <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == OP_LOAD) begin
        mode_q <= in_mode;
        last_q <= in_last;
      end
    end
  end

endmodule

FILE: rtl/core/ntmb_datapath.sv
// Datapath for the tanh backpropagation neuron: shared multiplier, accumulator,
// tanh ROM, neuron state, configuration registers and output register. Uses ntmb_pkg.
module ntmb_datapath
  import ntmb_pkg::*;
#(
  parameter int FRAC_BITS        = 12,
  parameter int TANH_TABLE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  in_item_t             in_item,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  ntmb_cmd_t            cmd,
  output ntmb_status_t         status
);

  localparam int XS_W    = ACC_W - FRAC_BITS;
  localparam int DERIV_W = (((30 - FRAC_BITS) > FRAC_BITS) ? (30 - FRAC_BITS) : FRAC_BITS) + 2;
  localparam int MUL_A_W = (XS_W > 32) ? XS_W : 32;
  localparam int MUL_B_W = (DERIV_W > 17) ? DERIV_W : 17;
  localparam int P_W     = MUL_A_W + MUL_B_W;
  localparam int T1_W    = P_W - DATA_W - FRAC_BITS;
  localparam int ROM_W   = FRAC_BITS + 1;
  localparam int IDX_W   = $clog2(TANH_TABLE_DEPTH + 1);
  localparam int MAG_W   = FRAC_BITS + 3;
  localparam int CMP_W   = (XS_W > MAG_W) ? XS_W : MAG_W;
  localparam int SCALE_W = MAG_W + IDX_W;
  localparam int SUM_W   = ACC_W + 1;

  localparam logic [MAG_W-1:0] TANH_LIM = MAG_W'(1) << (FRAC_BITS + 2);
  localparam logic signed [DERIV_W-1:0] ONE_FX = DERIV_W'(1) << FRAC_BITS;

  typedef logic [ROM_W-1:0] tanh_rom_t [TANH_TABLE_DEPTH+1];

  // shift-and-subtract quotient, used only while building the table
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // tanh(4*i/DEPTH) via a Q30 exp series, reciprocal and four squarings
  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t       rom;
    longint unsigned q30;
    longint unsigned y;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned e;
    q30 = 64'd1 << 30;
    for (int i = 0; i <= TANH_TABLE_DEPTH; i++) begin
      y    = div_u64(64'(i) << 30, 64'(2 * TANH_TABLE_DEPTH));
      term = q30;
      sum  = q30;
      for (int k = 1; k <= 12; k++) begin
        term = div_u64((term * y) >> 30, 64'(k));
        sum  = sum + term;
      end
      e = div_u64(64'd1 << 60, sum);
      for (int s = 0; s < 4; s++) begin
        e = (e * e) >> 30;
      end
      rom[i] = ROM_W'(div_u64(((q30 - e) << FRAC_BITS) + ((q30 + e) >> 1), q30 + e));
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

  // neuron state and configuration
  logic signed [ACC_W-1:0]  acc;
  logic signed [DATA_W-1:0] activation;
  logic signed [DATA_W-1:0] gradient;
  logic [DATA_W-1:0]        learn_rate;
  logic [DATA_W-1:0]        momentum;

  // per-request working registers
  logic signed [DATA_W-1:0]  val_q;
  logic signed [DATA_W-1:0]  wt_q;
  logic signed [DATA_W-1:0]  od_q;
  logic signed [P_W-1:0]     p_q;
  logic signed [DERIV_W-1:0] deriv_q;
  logic signed [T1_W-1:0]    t1_q;
  logic [IDX_W-1:0]          idx_q;
  logic                      neg_q;
  logic [ROM_W-1:0]          rom_q;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [P_W-1:0]     mul_p;
  logic                      mul_en;
  logic signed [16:0]        diff;
  logic signed [XS_W-1:0]    xs;
  logic [XS_W-1:0]           xs_mag;
  logic [MAG_W-1:0]          mag_cl;
  logic [SCALE_W-1:0]        scaled;
  logic [IDX_W-1:0]          idx;
  logic signed [SUM_W-1:0]   acc_sum;
  logic signed [ACC_W-1:0]   acc_sat;
  logic signed [ROM_W:0]     rom_s;
  logic signed [DATA_W-1:0]  act_sat;
  logic signed [DATA_W-1:0]  grad_sat;
  logic signed [DATA_W-1:0]  upd_res;
  logic signed [DATA_W-1:0]  upd_nw;
  logic                      res_step;

  assign status.out_free = !out_valid || !out_stall;

  assign res_step = (cmd.op == OP_ACT) || (cmd.op == OP_GRAD_H) ||
                    (cmd.op == OP_GRAD_O) || (cmd.op == OP_UPD);

  assign diff = 17'(val_q) - 17'(activation);
  assign xs   = XS_W'(acc >>> FRAC_BITS);

  // table index: floor(min(|x|, 4.0) * DEPTH / 4.0)
  assign xs_mag = xs[XS_W-1] ? XS_W'(-xs) : XS_W'(xs);
  assign mag_cl = (CMP_W'(xs_mag) > CMP_W'(TANH_LIM)) ? TANH_LIM : MAG_W'(xs_mag);
  assign scaled = SCALE_W'(mag_cl) * SCALE_W'(TANH_TABLE_DEPTH);
  assign idx    = IDX_W'(scaled >> (FRAC_BITS + 2));

  assign acc_sum = SUM_W'(acc) + SUM_W'(signed'(p_q[31:0]));
  assign acc_sat = (acc_sum[SUM_W-1] != acc_sum[SUM_W-2])
                   ? (acc_sum[SUM_W-1] ? ACC_MIN : ACC_MAX)
                   : acc_sum[ACC_W-1:0];

  assign rom_s    = $signed({1'b0, rom_q});
  assign act_sat  = sat16(64'(neg_q ? -rom_s : rom_s));
  assign grad_sat = sat16(64'(p_q >>> FRAC_BITS));
  assign upd_res  = sat16(64'(t1_q) + 64'(p_q >>> DATA_W));
  assign upd_nw   = sat16(64'(wt_q) + 64'(upd_res));

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (cmd.op)
      OP_MUL_VW: begin
        mul_a = MUL_A_W'(val_q);
        mul_b = MUL_B_W'(wt_q);
      end
      OP_MUL_AA: begin
        mul_a = MUL_A_W'(activation);
        mul_b = MUL_B_W'(activation);
      end
      OP_MUL_XD: begin
        mul_a = MUL_A_W'(xs);
        mul_b = MUL_B_W'(deriv_q);
      end
      OP_MUL_TD: begin
        mul_a = MUL_A_W'(diff);
        mul_b = MUL_B_W'(deriv_q);
      end
      OP_MUL_VG: begin
        mul_a = MUL_A_W'(val_q);
        mul_b = MUL_B_W'(gradient);
      end
      OP_MUL_LR: begin
        mul_a = MUL_A_W'(signed'(p_q[31:0]));
        mul_b = MUL_B_W'(signed'({1'b0, learn_rate}));
      end
      OP_MUL_MO: begin
        mul_a = MUL_A_W'(od_q);
        mul_b = MUL_B_W'(signed'({1'b0, momentum}));
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // control state, neuron state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      activation <= '0;
      gradient   <= '0;
      learn_rate <= LEARN_RATE_RESET;
      momentum   <= MOMENTUM_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_LEARN_RATE: learn_rate <= cfg_data;
          CFG_MOMENTUM:   momentum   <= cfg_data;
          default: ;
        endcase
      end
      if (res_step) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        OP_ACC: acc <= acc_sat;
        OP_ACT: begin
          activation <= act_sat;
          acc        <= '0;
        end
        OP_GRAD_H: begin
          gradient <= grad_sat;
          acc      <= '0;
        end
        OP_GRAD_O: gradient <= grad_sat;
        default: ;
      endcase
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      val_q <= in_item.value;
      wt_q  <= in_item.weight;
      od_q  <= in_item.old_delta;
    end
    if (mul_en) begin
      p_q <= mul_p;
    end
    if (cmd.op == OP_MUL_MO) begin
      // learning-rate term leaves the multiplier as the momentum product enters
      t1_q <= T1_W'(p_q >>> (DATA_W + FRAC_BITS));
    end
    if (cmd.op == OP_DERIV) begin
      deriv_q <= ONE_FX - DERIV_W'(p_q >>> FRAC_BITS);
    end
    if (cmd.op == OP_IDX) begin
      idx_q <= idx;
      neg_q <= acc[ACC_W-1];
    end
    if (cmd.op == OP_ROM) begin
      rom_q <= TANH_ROM[idx_q];
    end
    unique case (cmd.op)
      OP_ACT:    out_item <= '{kind: KIND_ACTIVATION, result: act_sat, new_weight: '0};
      OP_GRAD_H: out_item <= '{kind: KIND_GRADIENT, result: grad_sat, new_weight: '0};
      OP_GRAD_O: out_item <= '{kind: KIND_GRADIENT, result: grad_sat, new_weight: '0};
      OP_UPD:    out_item <= '{kind: KIND_UPDATE, result: upd_res, new_weight: upd_nw};
      default: ;
    endcase
  end

  a_result_has_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_ACT || cmd.op == OP_GRAD_H || cmd.op == OP_GRAD_O || cmd.op == OP_UPD)
    |-> status.out_free)
    else $error("result step issued while output register is held");

  a_act_kept: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_ACT |=> (activation == out_item.result) && (acc == '0) && out_valid)
    else $error("activation result and neuron state disagree");

  a_grad_kept: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_GRAD_H || cmd.op == OP_GRAD_O) |=> (gradient == out_item.result) && out_valid)
    else $error("gradient result and stored gradient disagree");

  a_update_no_state: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_MUL_VG || cmd.op == OP_MUL_LR || cmd.op == OP_MUL_MO || cmd.op == OP_UPD)
    |=> $stable(acc) && $stable(activation) && $stable(gradient))
    else $error("weight update changed neuron state");

endmodule

FILE: verif/tb_neuron_tanh_mac_backprop_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for neuron_tanh_mac_backprop_unit: queued requests, a
// bit-accurate neuron predictor with its own tanh table, and a result scoreboard.
// Depends on ntmb_pkg and the RTL under rtl/core.
module tb_neuron_tanh_mac_backprop_unit;
  import ntmb_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int FRAC            = 12;
  localparam int TANH_DEPTH      = 256;
  localparam int ITEMS_PER_PHASE = 158;
  localparam int N_PHASES        = 5;
  localparam int LONG_SUM_TERMS  = 520;
  localparam int LONG_HOLD       = 200;
  localparam int DRAIN_CYCLES    = 20;
  localparam int TIMEOUT_NS      = 5_000_000;

  localparam logic [CFG_IDX_W-1:0] CFG_BAD_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_HI = 2'd3;

  localparam logic signed [DATA_W-1:0] FX_MAX = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] FX_MIN = 16'sh8000;

  localparam longint ONE_FX  = longint'(1) << FRAC;
  localparam longint Q30     = longint'(1) << 30;
  localparam longint ACC_TOP = (longint'(1) << 39) - 1;
  localparam longint ACC_BOT = -(longint'(1) << 39);

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data  = '0;

  // predictor state and register copies
  longint acc_q   = 0;
  longint act_q   = 0;
  longint grad_q  = 0;
  longint rate_q  = longint'(LEARN_RATE_RESET);
  longint mom_q   = longint'(MOMENTUM_RESET);
  longint tanh_tab [0:TANH_DEPTH];

  in_item_t  req_queue[$];
  out_item_t pending_results[$];

  int  mismatches     = 0;
  bit  jitter_on      = 1'b1;
  bit  req_taken      = 1'b0;
  int  send_gap       = 0;
  int  stall_left     = 0;
  int  long_hold_reqs = 0;
  int  long_hold_seen = 0;
  int  long_hold_left = 0;

  neuron_tanh_mac_backprop_unit #(
    .FRAC_BITS(FRAC),
    .TANH_TABLE_DEPTH(TANH_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Append a request to the stimulus queue.
  function automatic void queue_req(input in_item_t req);
    req_queue = {req_queue, req};
  endfunction

  // Integer-exact table: exp series in Q30, reciprocal, four squarings, then round.
  function automatic void build_tanh_tab();
    longint unsigned y, term, sum, e;
    for (int i = 0; i <= TANH_DEPTH; i++) begin
      y = (longint'(i) << 30) / (2 * TANH_DEPTH);
      term = Q30;
      sum = Q30;
      for (int k = 1; k <= 12; k++) begin
        term = ((term * y) >> 30) / k;
        sum += term;
      end
      e = (longint'(1) << 60) / sum;
      for (int k = 0; k < 4; k++) begin
        e = (e * e) >> 30;
      end
      tanh_tab[i] = ((((Q30 - e) << FRAC) + (Q30 + e) / 2) / (Q30 + e));
    end
  endfunction

  function automatic longint tanh_fx(input longint x);
    longint mag, lim, idx;
    mag = (x < 0) ? -x : x;
    lim = 4 * ONE_FX;
    if (mag > lim) begin
      mag = lim;
    end
    idx = (mag * TANH_DEPTH) / lim;
    return (x < 0) ? -tanh_tab[idx] : tanh_tab[idx];
  endfunction

  function automatic longint sat_word(input longint v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  function automatic longint sat_acc(input longint v);
    return (v > ACC_TOP) ? ACC_TOP : ((v < ACC_BOT) ? ACC_BOT : v);
  endfunction

  // Advance the neuron state by one request; return 1 when it yields a result.
  function automatic bit neuron_step(input in_item_t req, output out_item_t res);
    longint v, w, od, deriv, t1, t2, r, nw;
    v = longint'($signed(req.value));
    w = longint'($signed(req.weight));
    od = longint'($signed(req.old_delta));
    deriv = ONE_FX - ((act_q * act_q) >>> FRAC);
    res = '0;
    case (req.mode)
      MODE_FORWARD, MODE_HIDDEN: begin
        acc_q = sat_acc(acc_q + v * w);
        if (!req.last) begin
          return 1'b0;
        end
        if (req.mode == MODE_FORWARD) begin
          act_q = sat_word(tanh_fx(acc_q >>> FRAC));
          res.kind = KIND_ACTIVATION;
          res.result = act_q[DATA_W-1:0];
        end else begin
          grad_q = sat_word(((acc_q >>> FRAC) * deriv) >>> FRAC);
          res.kind = KIND_GRADIENT;
          res.result = grad_q[DATA_W-1:0];
        end
        acc_q = 0;
      end
      MODE_OUT_GRAD: begin
        grad_q = sat_word(((v - act_q) * deriv) >>> FRAC);
        res.kind = KIND_GRADIENT;
        res.result = grad_q[DATA_W-1:0];
      end
      default: begin
        t1 = (rate_q * (v * grad_q)) >>> (16 + FRAC);
        t2 = (mom_q * od) >>> 16;
        r = sat_word(t1 + t2);
        nw = sat_word(w + r);
        res.kind = KIND_UPDATE;
        res.result = r[DATA_W-1:0];
        res.new_weight = nw[DATA_W-1:0];
      end
    endcase
    return 1'b1;
  endfunction

  function automatic void tally(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  function automatic void check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      tally($sformatf("%s mismatch: expected %0d, got %0d", field, want, got));
    end
  endfunction

  function automatic in_item_t make_req(input logic [MODE_W-1:0] mode,
                                        input logic signed [DATA_W-1:0] v,
                                        input logic signed [DATA_W-1:0] w,
                                        input logic signed [DATA_W-1:0] od,
                                        input logic last);
    in_item_t req;
    req.mode = mode;
    req.value = v;
    req.weight = w;
    req.old_delta = od;
    req.last = last;
    return req;
  endfunction

  // Mostly values scaled into the tanh knee, sometimes full range or exact extremes.
  function automatic logic signed [DATA_W-1:0] rand_fx();
    int sh;
    int r;
    case ($urandom_range(0, 5))
      0: r = $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: r = 32767;
          1: r = -32768;
          2: r = 4096;
          3: r = -4096;
          default: r = 0;
        endcase
      end
      default: begin
        sh = $urandom_range(2, 14);
        r = int'($urandom_range(0, 1 << (sh + 1))) - (1 << sh);
      end
    endcase
    return r[DATA_W-1:0];
  endfunction

  function automatic void push_terms(input logic [MODE_W-1:0] mode, input int n, input bit mixed);
    logic [MODE_W-1:0] m;
    for (int i = 0; i < n; i++) begin
      m = mixed ? (($urandom_range(0, 1) != 0) ? MODE_HIDDEN : MODE_FORWARD) : mode;
      queue_req(make_req(m, rand_fx(), rand_fx(), 16'($urandom), i == n - 1));
    end
  endfunction

  // Queue one random request sequence; return how many requests it holds.
  function automatic int push_sequence();
    int n;
    n = $urandom_range(1, 6);
    case ($urandom_range(0, 9))
      0, 1, 2: push_terms(MODE_FORWARD, n, 1'b0);
      3: begin
        n = 1;
        queue_req(make_req(MODE_OUT_GRAD, rand_fx(), 16'($urandom), 16'($urandom),
                           1'($urandom)));
      end
      4, 5: push_terms(MODE_HIDDEN, n, 1'b0);
      6, 7: begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          queue_req(make_req(MODE_UPDATE, rand_fx(), rand_fx(), rand_fx(), 1'($urandom)));
        end
      end
      8: push_terms(MODE_FORWARD, n, 1'b1);
      default: begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          queue_req(make_req(MODE_W'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 1'($urandom)));
        end
      end
    endcase
    return n;
  endfunction

  // Same-sign full-scale products drive the accumulator into its rail.
  function automatic void push_long_sum(input logic [MODE_W-1:0] mode,
                                        input logic signed [DATA_W-1:0] v,
                                        input logic signed [DATA_W-1:0] w);
    for (int i = 0; i < LONG_SUM_TERMS; i++) begin
      queue_req(make_req(mode, v, w, 16'($urandom), i == LONG_SUM_TERMS - 1));
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LEARN_RATE: rate_q = longint'(data);
      CFG_MOMENTUM:   mom_q = longint'(data);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait for all queued requests to go in and all results to come out.
  task automatic settle();
    do @(posedge clk);
    while (req_queue.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Request side: predict on acceptance, then refill at the falling edge.
  always @(posedge clk) begin
    out_item_t due;
    req_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      if (neuron_step(in_item, due)) begin
        pending_results = {pending_results, due};
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_valid <= 1'b0;
      end else if (req_queue.size() != 0) begin
        if (jitter_on && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else begin
          in_item <= req_queue.pop_front();
          in_valid <= 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: stall bursts, plus long hold-offs on request from the stimulus.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (long_hold_left > 0) begin
      long_hold_left = long_hold_left - 1;
      out_stall <= 1'b1;
    end else if (long_hold_seen != long_hold_reqs) begin
      long_hold_seen = long_hold_seen + 1;
      long_hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (jitter_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        tally($sformatf("unexpected result kind %0d result %0d new_weight %0d",
                        out_item.kind, $signed(out_item.result), $signed(out_item.new_weight)));
      end else begin
        want = pending_results.pop_front();
        check_field("kind", want.kind, out_item.kind);
        check_field("result", $signed(want.result), $signed(out_item.result));
        check_field("new_weight", $signed(want.new_weight), $signed(out_item.new_weight));
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[neuron_tanh_mac_backprop_unit] ERROR");
    $finish;
  end

  initial begin
    logic [DATA_W-1:0] rate_set [N_PHASES];
    logic [DATA_W-1:0] mom_set [N_PHASES];
    int pushed;
    build_tanh_tab();
    rate_set = '{16'hffff, 16'h0000, 16'($urandom), 16'd1, LEARN_RATE_RESET};
    mom_set = '{16'hffff, 16'h0000, 16'($urandom), 16'($urandom), MOMENTUM_RESET};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed requests under the reset register values
    queue_req(make_req(MODE_OUT_GRAD, FX_MAX, 16'sh0, 16'sh0, 1'b1));
    queue_req(make_req(MODE_OUT_GRAD, FX_MIN, FX_MAX, FX_MIN, 1'b0));
    queue_req(make_req(MODE_UPDATE, FX_MIN, FX_MAX, FX_MIN, 1'b0));
    queue_req(make_req(MODE_UPDATE, FX_MAX, FX_MIN, FX_MAX, 1'b1));
    queue_req(make_req(MODE_HIDDEN, FX_MAX, FX_MAX, 16'sh0, 1'b1));
    queue_req(make_req(MODE_FORWARD, FX_MAX, FX_MAX, 16'sh0, 1'b0));
    queue_req(make_req(MODE_FORWARD, FX_MIN, FX_MIN, 16'sh0, 1'b1));
    queue_req(make_req(MODE_FORWARD, FX_MIN, FX_MAX, 16'sh0, 1'b1));
    queue_req(make_req(MODE_OUT_GRAD, 16'sh0, 16'sh0, 16'sh0, 1'b1));
    queue_req(make_req(MODE_FORWARD, 16'sd4096, 16'sd4096, 16'sh0, 1'b1));
    queue_req(make_req(MODE_FORWARD, -16'sd4096, 16'sd2048, 16'sh0, 1'b1));
    queue_req(make_req(MODE_FORWARD, 16'sh0, 16'sh0, 16'sh0, 1'b1));
    queue_req(make_req(MODE_FORWARD, 16'sd8192, 16'sd8192, 16'sh0, 1'b1));
    queue_req(make_req(MODE_FORWARD, 16'sd8192, 16'sd8193, 16'sh0, 1'b1));
    queue_req(make_req(MODE_FORWARD, -16'sd1, 16'sd1, 16'sh0, 1'b1));
    queue_req(make_req(MODE_FORWARD, 16'sd4096, 16'sd1024, 16'sh0, 1'b0));
    queue_req(make_req(MODE_HIDDEN, -16'sd2048, 16'sd4096, 16'sh0, 1'b1));
    queue_req(make_req(MODE_FORWARD, 16'sd3000, 16'sd3000, 16'sh0, 1'b1));
    queue_req(make_req(MODE_OUT_GRAD, 16'sd4096, 16'sh0, 16'sh0, 1'b0));
    queue_req(make_req(MODE_HIDDEN, 16'sd1000, 16'sd2000, 16'sh0, 1'b1));
    queue_req(make_req(MODE_UPDATE, 16'sd3000, -16'sd1200, 16'sd500, 1'b0));
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      if (p == 0) begin
        write_reg(CFG_BAD_LO, 16'($urandom));
        write_reg(CFG_BAD_HI, 16'($urandom));
      end
      write_reg(CFG_LEARN_RATE, rate_set[p]);
      write_reg(CFG_MOMENTUM, mom_set[p]);
      jitter_on = (p != N_PHASES - 1);
      // hold results back long enough that the block backs up into its input
      if (p == 2 || p == 3) begin
        long_hold_reqs++;
      end
      pushed = 0;
      while (pushed < ITEMS_PER_PHASE) begin
        pushed += push_sequence();
      end
      if (p == 1) begin
        push_long_sum(MODE_FORWARD, FX_MIN, FX_MIN);
      end
      if (p == 3) begin
        push_long_sum(MODE_HIDDEN, FX_MIN, FX_MAX);
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("[neuron_tanh_mac_backprop_unit] OK");
    end else begin
      $display("[neuron_tanh_mac_backprop_unit] ERROR");
    end
    $finish;
  end

endmodule
